@@ design/assert_macros.svh @@
// assertion macros shared by the execute unit files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/ieu_pkg.sv @@
// types, command codes and reset constants of the integer execute unit
package ieu_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = 5;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 5;

    localparam logic [CMD_W-1:0] CMD_LI    = 5'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE  = 5'd1;
    localparam logic [CMD_W-1:0] CMD_ADD   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_ADDU  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_SUB   = 5'd4;
    localparam logic [CMD_W-1:0] CMD_SUBU  = 5'd5;
    localparam logic [CMD_W-1:0] CMD_ADDI  = 5'd6;
    localparam logic [CMD_W-1:0] CMD_ADDIU = 5'd7;
    localparam logic [CMD_W-1:0] CMD_MULT  = 5'd8;
    localparam logic [CMD_W-1:0] CMD_MULTU = 5'd9;
    localparam logic [CMD_W-1:0] CMD_MFLO  = 5'd10;
    localparam logic [CMD_W-1:0] CMD_MFHI  = 5'd11;
    localparam logic [CMD_W-1:0] CMD_DIV   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_DIVU  = 5'd13;
    localparam logic [CMD_W-1:0] CMD_SEQ   = 5'd14;
    localparam logic [CMD_W-1:0] CMD_SNE   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_SLT   = 5'd16;
    localparam logic [CMD_W-1:0] CMD_SGT   = 5'd17;
    localparam logic [CMD_W-1:0] CMD_SLE   = 5'd18;
    localparam logic [CMD_W-1:0] CMD_SGE   = 5'd19;
    localparam logic [CMD_W-1:0] CMD_SLTI  = 5'd20;
    localparam logic [CMD_W-1:0] CMD_READ  = 5'd21;

    localparam logic [REG_IDX_W-1:0] GP_INDEX = 5'd28;
    localparam logic [REG_IDX_W-1:0] SP_INDEX = 5'd29;
    localparam logic [WORD_W-1:0]    GP_RESET = 32'd268468224;
    localparam logic [WORD_W-1:0]    SP_RESET = 32'd2147479548;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [REG_IDX_W-1:0] dest_reg;
        logic [REG_IDX_W-1:0] src_a_reg;
        logic [REG_IDX_W-1:0] src_b_reg;
        logic signed [31:0]   immediate;
    } ieu_cmd_t;

    typedef struct packed {
        logic                 wrote;
        logic [REG_IDX_W-1:0] written_reg;
        logic signed [31:0]   written_value;
        logic signed [31:0]   hi_value;
        logic signed [31:0]   lo_value;
        logic signed [31:0]   read_value;
        logic                 divide_by_zero;
    } ieu_res_t;

    typedef struct packed {
        logic start;
        logic is_signed;
    } ieu_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ieu_div_stat_t;

    // value an entry holds until it is first written
    function automatic logic [WORD_W-1:0] reset_value(input logic [REG_IDX_W-1:0] idx);
        logic [WORD_W-1:0] v;
        v = '0;
        if (idx == GP_INDEX)
        begin
            v = GP_RESET;
        end
        else if (idx == SP_INDEX)
        begin
            v = SP_RESET;
        end
        return v;
    endfunction

endpackage

@@ design/ieu_regfile.sv @@
// general register file: synchronous two-read one-write memory with per-entry valid bits
`include "assert_macros.svh"

module ieu_regfile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [ieu_pkg::REG_IDX_W-1:0] raddr_a,
    input  logic [ieu_pkg::REG_IDX_W-1:0] raddr_b,
    output logic [ieu_pkg::WORD_W-1:0]    rdata_a,
    output logic [ieu_pkg::WORD_W-1:0]    rdata_b,
    input  logic                          we,
    input  logic [ieu_pkg::REG_IDX_W-1:0] waddr,
    input  logic [ieu_pkg::WORD_W-1:0]    wdata
);

    logic [ieu_pkg::WORD_W-1:0]    mem [ieu_pkg::REG_COUNT];
    logic [ieu_pkg::REG_COUNT-1:0] valid_reg;
    logic [ieu_pkg::WORD_W-1:0]    mem_a_reg;
    logic [ieu_pkg::WORD_W-1:0]    mem_b_reg;
    logic [ieu_pkg::REG_IDX_W-1:0] addr_a_reg;
    logic [ieu_pkg::REG_IDX_W-1:0] addr_b_reg;
    logic                          valid_a_reg;
    logic                          valid_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            mem_a_reg  <= mem[raddr_a];
            mem_b_reg  <= mem[raddr_b];
            addr_a_reg <= raddr_a;
            addr_b_reg <= raddr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_a_reg <= valid_reg[raddr_a];
                valid_b_reg <= valid_reg[raddr_b];
            end
        end
    end

    // never-written entries show their reset contents
    assign rdata_a = valid_a_reg ? mem_a_reg : ieu_pkg::reset_value(addr_a_reg);
    assign rdata_b = valid_b_reg ? mem_b_reg : ieu_pkg::reset_value(addr_b_reg);

    `ASSERT_IMPLY(a_no_write_zero, clk, rst_n, we, waddr != '0)

endmodule

@@ design/ieu_divider.sv @@
// iterative restoring divider, one quotient bit per cycle, signed or unsigned
`include "assert_macros.svh"

module ieu_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ieu_pkg::ieu_div_ctrl_t     ctrl,
    input  logic [ieu_pkg::WORD_W-1:0] dividend,
    input  logic [ieu_pkg::WORD_W-1:0] divisor,
    output ieu_pkg::ieu_div_stat_t     status,
    output logic [ieu_pkg::WORD_W-1:0] quotient,
    output logic [ieu_pkg::WORD_W-1:0] remainder
);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_FIX  = 2'd2;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [4:0]                  count_reg;
    logic                        done_reg;
    logic [ieu_pkg::WORD_W-1:0]  quo_reg;
    logic [ieu_pkg::WORD_W-1:0]  rem_reg;
    logic [ieu_pkg::WORD_W-1:0]  dvs_reg;
    logic                        neg_q_reg;
    logic                        neg_r_reg;
    logic [ieu_pkg::WORD_W-1:0]  dvd_mag;
    logic [ieu_pkg::WORD_W-1:0]  dvs_mag;
    logic [ieu_pkg::WORD_W:0]    trial;
    logic [ieu_pkg::WORD_W:0]    diff;

    assign dvd_mag = (ctrl.is_signed && dividend[31]) ? (~dividend + 32'd1) : dividend;
    assign dvs_mag = (ctrl.is_signed && divisor[31])  ? (~divisor + 32'd1)  : divisor;

    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (count_reg == '0)
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DV_FIX);
            if (state_reg == DV_IDLE)
            begin
                count_reg <= '1;
            end
            else if (state_reg == DV_RUN)
            begin
                count_reg <= count_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (ctrl.start)
                begin
                    quo_reg   <= dvd_mag;
                    rem_reg   <= '0;
                    dvs_reg   <= dvs_mag;
                    neg_q_reg <= ctrl.is_signed && (dividend[31] ^ divisor[31]);
                    neg_r_reg <= ctrl.is_signed && dividend[31];
                end
            end
            DV_RUN:
            begin
                // shift in one dividend bit, keep the difference when it fits
                rem_reg <= diff[32] ? trial[31:0] : diff[31:0];
                quo_reg <= {quo_reg[30:0], ~diff[32]};
            end
            DV_FIX:
            begin
                // apply signs: quotient truncates toward zero, remainder follows dividend
                quo_reg <= neg_q_reg ? (~quo_reg + 32'd1) : quo_reg;
                rem_reg <= neg_r_reg ? (~rem_reg + 32'd1) : rem_reg;
            end
            default:
            begin
                quo_reg <= quo_reg;
            end
        endcase
    end

    assign status.busy = (state_reg != DV_IDLE);
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

    `ASSERT_NEXT(a_start_runs, clk, rst_n, ctrl.start && (state_reg == DV_IDLE), state_reg == DV_RUN)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)

endmodule

@@ design/integer_execute_unit_with_hi_lo.sv @@
// top level of the integer execute unit with register file and hi/lo pair
//
//  channel | valid     | stall     | payload                    | beat
//  --------+-----------+-----------+----------------------------+--------------------------
//  command | cmd_valid | cmd_stall | cmd_data (ieu_cmd_t)       | one decoded instruction
//  result  | res_valid | res_stall | res_data (ieu_res_t)       | one result per instruction
//
// an instruction steps through exec and done states between accepts; mult/multu add a mul state
// (one registered 33x33 multiply) and div/divu a div state, held while the divider
// produces one quotient bit per cycle plus sign fix-up; a zero divisor skips the divider
// reset clears control state, hi/lo and all register file valid bits; no clearing pass
// a result waiting under res_stall does not block the next accept, only the next
// item's writeback, which then holds the command input stalled
`include "assert_macros.svh"

module integer_execute_unit_with_hi_lo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  ieu_pkg::ieu_cmd_t cmd_data,
    output logic              res_valid,
    input  logic              res_stall,
    output ieu_pkg::ieu_res_t res_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    ieu_pkg::ieu_cmd_t             item_reg;
    ieu_pkg::ieu_res_t             pend_reg;
    ieu_pkg::ieu_res_t             pend_next;
    ieu_pkg::ieu_res_t             out_reg;
    logic                          out_valid_reg;
    logic [ieu_pkg::WORD_W-1:0]    hi_reg;
    logic [ieu_pkg::WORD_W-1:0]    lo_reg;
    logic [63:0]                   prod_reg;

    logic                          accept;
    logic                          out_free;
    logic                          commit;
    logic [ieu_pkg::REG_IDX_W-1:0] raddr_a;
    logic [ieu_pkg::WORD_W-1:0]    opa;
    logic [ieu_pkg::WORD_W-1:0]    opb;
    logic                          rf_we;

    logic                          ex_wr;
    logic [ieu_pkg::WORD_W-1:0]    ex_val;
    logic [ieu_pkg::WORD_W-1:0]    ex_rdval;
    logic                          ex_is_mult;
    logic                          ex_is_div;
    logic                          ex_signed;
    logic                          ex_div_zero;
    ieu_pkg::ieu_res_t             ex_res;

    logic signed [32:0]            mul_a;
    logic signed [32:0]            mul_b;
    logic signed [65:0]            mul_full;

    ieu_pkg::ieu_div_ctrl_t        div_ctrl;
    ieu_pkg::ieu_div_stat_t        div_stat;
    logic [ieu_pkg::WORD_W-1:0]    div_quo;
    logic [ieu_pkg::WORD_W-1:0]    div_rem;

    // one instruction in flight; the previous writeback lands before the next read
    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !res_stall;
    assign commit    = (state_reg == ST_DONE) && out_free;
    assign rf_we     = commit && pend_reg.wrote;

    // read command fetches dest_reg through port a
    assign raddr_a = (cmd_data.command == ieu_pkg::CMD_READ) ? cmd_data.dest_reg
                                                            : cmd_data.src_a_reg;

    ieu_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .raddr_a (raddr_a),
        .raddr_b (cmd_data.src_b_reg),
        .rdata_a (opa),
        .rdata_b (opb),
        .we      (rf_we),
        .waddr   (pend_reg.written_reg),
        .wdata   (pend_reg.written_value)
    );

    // execute stage: operands come from the registered memory outputs, or reset contents for never-written entries
    always_comb
    begin
        ex_wr      = 1'b0;
        ex_val     = '0;
        ex_rdval   = '0;
        ex_is_mult = 1'b0;
        ex_is_div  = 1'b0;
        ex_signed  = 1'b0;
        case (item_reg.command)
            ieu_pkg::CMD_LI:
            begin
                ex_wr  = 1'b1;
                ex_val = item_reg.immediate;
            end
            ieu_pkg::CMD_MOVE:
            begin
                ex_wr  = 1'b1;
                ex_val = opa;
            end
            ieu_pkg::CMD_ADD, ieu_pkg::CMD_ADDU:
            begin
                ex_wr  = 1'b1;
                ex_val = opa + opb;
            end
            ieu_pkg::CMD_SUB, ieu_pkg::CMD_SUBU:
            begin
                ex_wr  = 1'b1;
                ex_val = opa - opb;
            end
            ieu_pkg::CMD_ADDI, ieu_pkg::CMD_ADDIU:
            begin
                ex_wr  = 1'b1;
                ex_val = opa + item_reg.immediate;
            end
            ieu_pkg::CMD_MULT:
            begin
                ex_is_mult = 1'b1;
                ex_signed  = 1'b1;
            end
            ieu_pkg::CMD_MULTU:
            begin
                ex_is_mult = 1'b1;
            end
            ieu_pkg::CMD_MFLO:
            begin
                ex_wr  = 1'b1;
                ex_val = lo_reg;
            end
            ieu_pkg::CMD_MFHI:
            begin
                ex_wr  = 1'b1;
                ex_val = hi_reg;
            end
            ieu_pkg::CMD_DIV:
            begin
                ex_is_div = 1'b1;
                ex_signed = 1'b1;
            end
            ieu_pkg::CMD_DIVU:
            begin
                ex_is_div = 1'b1;
            end
            ieu_pkg::CMD_SEQ:
            begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, opa == opb};
            end
            ieu_pkg::CMD_SNE:
            begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, opa != opb};
            end
            ieu_pkg::CMD_SLT:
            begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, $signed(opa) < $signed(opb)};
            end
            ieu_pkg::CMD_SGT:
            begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, $signed(opa) > $signed(opb)};
            end
            ieu_pkg::CMD_SLE:
            begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, $signed(opa) <= $signed(opb)};
            end
            ieu_pkg::CMD_SGE:
            begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, $signed(opa) >= $signed(opb)};
            end
            ieu_pkg::CMD_SLTI:
            begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, $signed(opa) < item_reg.immediate};
            end
            ieu_pkg::CMD_READ:
            begin
                ex_rdval = opa;
            end
            default:
            begin
                // unused codes change nothing
                ex_wr = 1'b0;
            end
        endcase
    end

    assign ex_div_zero = ex_is_div && (opb == '0);

    // writes to register zero are dropped and reported as no write
    always_comb
    begin
        ex_res                = '0;
        ex_res.wrote          = ex_wr && (item_reg.dest_reg != '0);
        ex_res.written_reg    = ex_res.wrote ? item_reg.dest_reg : '0;
        ex_res.written_value  = ex_res.wrote ? ex_val : '0;
        ex_res.hi_value       = hi_reg;
        ex_res.lo_value       = lo_reg;
        ex_res.read_value     = ex_rdval;
        ex_res.divide_by_zero = ex_div_zero;
    end

    // 33x33 signed multiply covers both signed and unsigned operands
    assign mul_a    = {ex_signed & opa[31], opa};
    assign mul_b    = {ex_signed & opb[31], opb};
    assign mul_full = mul_a * mul_b;

    assign div_ctrl.start     = (state_reg == ST_EXEC) && ex_is_div && !ex_div_zero;
    assign div_ctrl.is_signed = ex_signed;

    ieu_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (opa),
        .divisor   (opb),
        .status    (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                pend_next = ex_res;
                if (ex_is_mult)
                begin
                    state_next = ST_MUL;
                end
                else if (div_ctrl.start)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                pend_next.hi_value = prod_reg[63:32];
                pend_next.lo_value = prod_reg[31:0];
                state_next         = ST_DONE;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    pend_next.hi_value = div_rem;
                    pend_next.lo_value = div_quo;
                    state_next         = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                hi_reg        <= pend_reg.hi_value;
                lo_reg        <= pend_reg.lo_value;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (accept)
        begin
            item_reg <= cmd_data;
        end
        if (state_reg == ST_EXEC)
        begin
            prod_reg <= mul_full[63:0];
        end
        if (commit)
        begin
            out_reg <= pend_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    `ASSERT_IMPLY(a_div_start_idle, clk, rst_n, div_ctrl.start, !div_stat.busy)
    `ASSERT_NEXT(a_writeback_idle, clk, rst_n, rf_we, state_reg == ST_IDLE)

endmodule
